@@ rtl/utd_pkg.sv @@
package utd_pkg;

  // Status codes of a result word
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ILLEGAL   = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned CNT_W = 32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_word_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [1:0]       status;
    logic [CNT_W-1:0] char_count;
    logic [CNT_W-1:0] bytes_consumed;
    logic             final_result;
  } out_word_t;

  // Number of continuation bytes announced by a lead byte
  function automatic logic [2:0] trail_count(input logic [7:0] b);
    logic [2:0] n;
    if (b < 8'hC0)      n = 3'd0;
    else if (b < 8'hE0) n = 3'd1;
    else if (b < 8'hF0) n = 3'd2;
    else if (b < 8'hF8) n = 3'd3;
    else if (b < 8'hFC) n = 3'd4;
    else                n = 3'd5;
    return n;
  endfunction

  // Payload bits kept from a lead byte
  function automatic logic [7:0] lead_mask(input logic [2:0] n);
    logic [7:0] m;
    if (n == 3'd0) m = 8'h7F;
    else           m = 8'h3F >> n;
    return m;
  endfunction

  // Leads that can never start a well-formed sequence
  function automatic logic lead_bad(input logic [7:0] b);
    return ((b >= 8'h80) && (b < 8'hC2)) || (b > 8'hF4);
  endfunction

  function automatic logic cont_ok(input logic [7:0] b);
    return (b >= 8'h80) && (b <= 8'hBF);
  endfunction

  // Restricted second-byte ranges after E0, ED, F0 and F4
  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    case (lead)
      8'hE0: begin
        ok = (b >= 8'hA0) && (b <= 8'hBF);
      end
      8'hED: begin
        ok = (b >= 8'h80) && (b <= 8'h9F);
      end
      8'hF0: begin
        ok = (b >= 8'h90) && (b <= 8'hBF);
      end
      8'hF4: begin
        ok = (b >= 8'h80) && (b <= 8'h8F);
      end
      default: begin
        ok = cont_ok(b);
      end
    endcase
    return ok;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [2:0] k);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + (CNT_W+1)'(k);
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

@@ rtl/utd_core.sv @@
module utd_core
  import utd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  in_word_t  word,
  output logic      res_valid,
  output out_word_t res_word
);

  logic [7:0]       lead_r,   lead_nxt;
  logic [CP_W-1:0]  acc_r,    acc_nxt;
  logic [2:0]       needed_r, needed_nxt;
  logic [2:0]       seen_r,   seen_nxt;
  logic             bad_r,    bad_nxt;
  logic             halted_r, halted_nxt;
  logic [CNT_W-1:0] chars_r,  chars_nxt;
  logic [CNT_W-1:0] bytes_r,  bytes_nxt;

  logic [2:0] n;
  logic [7:0] b;
  logic       fin;

  assign b   = word.data_byte;
  assign fin = word.stream_end;
  assign n   = trail_count(b);

  always_comb begin
    lead_nxt   = lead_r;
    acc_nxt    = acc_r;
    needed_nxt = needed_r;
    seen_nxt   = seen_r;
    bad_nxt    = bad_r;
    halted_nxt = halted_r;
    chars_nxt  = chars_r;
    bytes_nxt  = bytes_r;
    res_valid  = 1'b0;
    res_word   = '0;

    if (go) begin
      if (halted_r) begin
        // drop bytes until the end mark, then start clean
        if (fin) begin
          lead_nxt   = '0;
          acc_nxt    = '0;
          needed_nxt = '0;
          seen_nxt   = '0;
          bad_nxt    = 1'b0;
          halted_nxt = 1'b0;
          chars_nxt  = '0;
          bytes_nxt  = '0;
        end
      end else begin
        if (needed_r == 3'd0) begin
          lead_nxt   = b;
          needed_nxt = n;
          seen_nxt   = 3'd0;
          bad_nxt    = lead_bad(b);
          acc_nxt    = {{(CP_W-8){1'b0}}, b & lead_mask(n)};
        end else begin
          seen_nxt = seen_r + 3'd1;
          if (seen_nxt == 3'd1) begin
            if (!second_ok(lead_r, b)) bad_nxt = 1'b1;
          end else if (!cont_ok(b)) begin
            bad_nxt = 1'b1;
          end
          acc_nxt = {acc_r[CP_W-7:0], b[5:0]};
        end

        if (seen_nxt == needed_nxt) begin
          res_valid = 1'b1;
          if (bad_nxt) begin
            res_word.status         = ST_ILLEGAL;
            res_word.char_count     = chars_r;
            res_word.bytes_consumed = bytes_r;
            res_word.final_result   = 1'b1;
            halted_nxt              = !fin;
          end else begin
            chars_nxt               = sat_add(chars_r, 3'd1);
            bytes_nxt               = sat_add(bytes_r, needed_nxt + 3'd1);
            res_word.code_point     = acc_nxt;
            res_word.status         = ST_OK;
            res_word.char_count     = chars_nxt;
            res_word.bytes_consumed = bytes_nxt;
            res_word.final_result   = fin;
          end
          needed_nxt = 3'd0;
          seen_nxt   = 3'd0;
          if (fin) begin
            lead_nxt   = '0;
            acc_nxt    = '0;
            bad_nxt    = 1'b0;
            halted_nxt = 1'b0;
            chars_nxt  = '0;
            bytes_nxt  = '0;
          end
        end else if (fin) begin
          // stream ended inside a sequence
          res_valid               = 1'b1;
          res_word.status         = ST_EXHAUSTED;
          res_word.char_count     = chars_r;
          res_word.bytes_consumed = bytes_r;
          res_word.final_result   = 1'b1;
          lead_nxt   = '0;
          acc_nxt    = '0;
          needed_nxt = '0;
          seen_nxt   = '0;
          bad_nxt    = 1'b0;
          halted_nxt = 1'b0;
          chars_nxt  = '0;
          bytes_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r   <= '0;
      acc_r    <= '0;
      needed_r <= '0;
      seen_r   <= '0;
      bad_r    <= 1'b0;
      halted_r <= 1'b0;
      chars_r  <= '0;
      bytes_r  <= '0;
    end else begin
      lead_r   <= lead_nxt;
      acc_r    <= acc_nxt;
      needed_r <= needed_nxt;
      seen_r   <= seen_nxt;
      bad_r    <= bad_nxt;
      halted_r <= halted_nxt;
      chars_r  <= chars_nxt;
      bytes_r  <= bytes_nxt;
    end
  end

endmodule

@@ rtl/utd_out_buf.sv @@
module utd_out_buf
  import utd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_word_t push_word,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic [1:0] cnt_r, cnt_nxt;
  out_word_t  head_r, head_nxt;
  out_word_t  tail_r, tail_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_word  = head_r;
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid && !out_stall;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (push && pop) begin
      if (cnt_r == 2'd1) begin
        head_nxt = push_word;
      end else begin
        head_nxt = tail_r;
        tail_nxt = push_word;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) head_nxt = push_word;
      else               tail_nxt = push_word;
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop) begin
      head_nxt = tail_r;
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

@@ rtl/utd_top_unused_guard.sv @@
module utd_top_unused_guard
  import utd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  in_word_t in_word,
  input  logic     take,
  input  logic     advance,
  output logic     s1_valid,
  output in_word_t s1_word
);

  // Input register: load a word on accept, drain it when the core advances
  logic     valid_r, valid_nxt;
  in_word_t word_r,  word_nxt;

  always_comb begin
    valid_nxt = valid_r;
    word_nxt  = word_r;
    if (take) begin
      valid_nxt = 1'b1;
      word_nxt  = in_word;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  assign s1_valid = valid_r;
  assign s1_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    word_r <= word_nxt;
  end

endmodule

@@ rtl/utf8_to_utf32_decoder_top.sv @@
// The input register holds a word, then the result buffer holds its result.
// Throughput: one byte per cycle while out_stall stays low; the per-byte
// decode step between the input register and the result buffer sets this.
// Reset (rst_n low, synchronous) clears the decode state, both counters and
// the valid flags of the input register and the two-entry result buffer.
module utf8_to_utf32_decoder_top
  import utd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      s1_valid;
  in_word_t  s1_word;
  logic      buf_full;
  logic      advance;
  logic      take;
  logic      res_valid;
  out_word_t res_word;

  // Decode the held byte whenever the result buffer has a free entry.
  // The buffer fill alone decides this, so in_stall comes from registers
  // and never from out_stall directly.
  assign advance  = s1_valid && !buf_full;
  assign in_stall = s1_valid && buf_full;
  assign take     = in_valid && !in_stall;

  utd_top_unused_guard u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .take     (take),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_word  (s1_word)
  );

  // One decode step per byte: lead/continuation check, accumulate, count
  utd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (advance),
    .word      (s1_word),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  // Result register with a skid entry: hold a word while the sink stalls
  utd_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_word (res_word),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

@@ sim/tb.sv @@
module tb;
  import utd_pkg::*;

  // Run-length knobs
  localparam int LIMIT       = 300000;  // cycles before the run is declared hung
  localparam int HOLD_AT     = 300;     // accepted words before the long receiver hold-off
  localparam int HOLD_CYCLES = 120;     // length of that hold-off
  localparam int CALM_N      = 80;      // last words of the run go without any idling
  localparam int TAIL        = 20;      // quiet cycles after the last expected result

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // Stimulus and scoreboard storage
  in_word_t   src_bytes[$];   // words still to be offered to the decoder
  logic [7:0] stream_buf[$];  // one stream being assembled before it is queued
  out_word_t  exp_words[$];   // predicted result words, oldest first

  int   total_n = 0;
  int   drain_point = 0;
  int   accepted_n = 0;
  int   cycle_n = 0;
  int   mismatch_n = 0;
  int   checked_n = 0;
  logic in_took = 1'b0;
  logic holding = 1'b0;
  logic calm;

  // Predictor state: one decoder, cleared at every end of stream
  logic [7:0]  dec_lead;
  logic [20:0] dec_acc;
  logic [2:0]  dec_need;
  logic [2:0]  dec_seen;
  logic        dec_bad;
  logic        dec_halted;
  logic [31:0] dec_chars;
  logic [31:0] dec_bytes;

  utf8_to_utf32_decoder_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #6 clk = ~clk;

  // Switch both sides to full rate near the end of the run
  assign calm = (accepted_n + CALM_N >= total_n);

  task automatic clear_decoder();
    dec_lead   = '0;
    dec_acc    = '0;
    dec_need   = '0;
    dec_seen   = '0;
    dec_bad    = 1'b0;
    dec_halted = 1'b0;
    dec_chars  = '0;
    dec_bytes  = '0;
  endtask

  function automatic logic [31:0] sat_count(input logic [31:0] a, input logic [31:0] k);
    return (a > 32'hFFFF_FFFF - k) ? 32'hFFFF_FFFF : a + k;
  endfunction

  // Advance the predicted decoder by one accepted byte; queue the result word
  // that byte produces, if any.
  task automatic decode_byte(input in_word_t w);
    logic [7:0] b;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] keep;
    logic [2:0] len;
    out_word_t  r;
    b = w.data_byte;
    r = '0;
    // After an error, drop everything up to and including the end mark
    if (dec_halted) begin
      if (w.stream_end) clear_decoder();
      return;
    end
    if (dec_need == 3'd0) begin
      // Lead byte: length of the sequence and payload bits it carries
      casez (b)
        8'b110?????: begin
          dec_need = 3'd1;
          keep = 8'h1F;
        end
        8'b1110????: begin
          dec_need = 3'd2;
          keep = 8'h0F;
        end
        8'b11110???: begin
          dec_need = 3'd3;
          keep = 8'h07;
        end
        8'b111110??: begin
          dec_need = 3'd4;
          keep = 8'h03;
        end
        8'b111111??: begin
          dec_need = 3'd5;
          keep = 8'h01;
        end
        default: begin
          dec_need = 3'd0;
          keep = 8'h7F;
        end
      endcase
      dec_lead = b;
      dec_seen = 3'd0;
      // Stray continuations, overlong two-byte leads and leads past F4
      dec_bad  = ((b >= 8'h80) && (b < 8'hC2)) || (b > 8'hF4);
      dec_acc  = 21'(b & keep);
    end else begin
      dec_seen = dec_seen + 3'd1;
      lo = 8'h80;
      hi = 8'hBF;
      // Tighter second-byte windows rule out overlongs, surrogates and > 10FFFF
      if (dec_seen == 3'd1) begin
        case (dec_lead)
          8'hE0: lo = 8'hA0;
          8'hED: hi = 8'h9F;
          8'hF0: lo = 8'h90;
          8'hF4: hi = 8'h8F;
          default: ;
        endcase
      end
      if ((b < lo) || (b > hi)) dec_bad = 1'b1;
      dec_acc = {dec_acc[14:0], b[5:0]};
    end
    if (dec_seen == dec_need) begin
      len = dec_need + 3'd1;
      dec_need = 3'd0;
      dec_seen = 3'd0;
      if (dec_bad) begin
        r.status = ST_ILLEGAL;
        r.final_result = 1'b1;
        dec_halted = 1'b1;
      end else begin
        dec_chars = sat_count(dec_chars, 32'd1);
        dec_bytes = sat_count(dec_bytes, 32'(len));
        r.code_point = dec_acc;
        r.status = ST_OK;
        r.final_result = w.stream_end;
      end
    end else if (w.stream_end) begin
      // Stream ended mid-sequence: exhaustion wins over a known bad sequence
      r.status = ST_EXHAUSTED;
      r.final_result = 1'b1;
    end else begin
      return;
    end
    r.char_count = dec_chars;
    r.bytes_consumed = dec_bytes;
    exp_words.push_back(r);
    if (w.stream_end) clear_decoder();
  endtask

  // Queue the assembled stream, end mark on its last byte
  task automatic flush_stream();
    in_word_t w;
    foreach (stream_buf[i]) begin
      w.data_byte  = stream_buf[i];
      w.stream_end = (i == stream_buf.size() - 1);
      src_bytes.push_back(w);
    end
    stream_buf.delete();
  endtask

  // Append a well-formed character of the given encoded length
  task automatic add_char(input int unsigned len);
    logic [20:0] cp;
    case (len)
      1: begin
        cp = 21'($urandom_range(0, 'h7F));
        stream_buf.push_back({1'b0, cp[6:0]});
      end
      2: begin
        cp = 21'($urandom_range('h80, 'h7FF));
        stream_buf.push_back({3'b110, cp[10:6]});
        stream_buf.push_back({2'b10, cp[5:0]});
      end
      3: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        // Move surrogates D800-DFFF down to C800-CFFF
        if (cp[15:11] == 5'b11011) cp[12] = 1'b0;
        stream_buf.push_back({4'b1110, cp[15:12]});
        stream_buf.push_back({2'b10, cp[11:6]});
        stream_buf.push_back({2'b10, cp[5:0]});
      end
      default: begin
        cp = 21'($urandom_range('h10000, 'h10FFFF));
        stream_buf.push_back({5'b11110, cp[20:18]});
        stream_buf.push_back({2'b10, cp[17:12]});
        stream_buf.push_back({2'b10, cp[11:6]});
        stream_buf.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // One random stream: mostly clean text, some corrupted, cut short or noise
  task automatic add_random_stream();
    int unsigned kind;
    int unsigned r;
    int unsigned l;
    kind = $urandom_range(0, 19);
    stream_buf.delete();
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 9);
      add_char(r < 4 ? 1 : r < 6 ? 2 : r < 8 ? 3 : 4);
    end
    case (kind)
      15, 16: begin
        // Overwrite one byte with anything
        stream_buf[$urandom_range(0, stream_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end
      17: begin
        // End the stream inside a multi-byte character
        l = $urandom_range(2, 4);
        add_char(l);
        repeat ($urandom_range(1, l - 1)) void'(stream_buf.pop_back());
      end
      18: begin
        // Forbidden lead followed by a run of continuation bytes
        if ($urandom_range(0, 1) != 0) stream_buf.push_back(8'($urandom_range('hC0, 'hC1)));
        else stream_buf.push_back(8'($urandom_range('hF5, 'hFF)));
        repeat ($urandom_range(0, 5)) stream_buf.push_back(8'($urandom_range('h80, 'hBF)));
        if ($urandom_range(0, 1) != 0) add_char(1);
      end
      19: begin
        stream_buf.delete();
        repeat ($urandom_range(1, 8)) stream_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    flush_stream();
  endtask

  // Sender: offer the next word once the previous one is taken; hold it while stalled
  always @(negedge clk) begin : driver
    int unsigned gap_left;
    bit          drain_wait;
    if (rst_n && (!in_valid || in_took)) begin
      // After the directed part, pause until every predicted word is out
      if (in_took && (accepted_n == drain_point)) drain_wait = 1'b1;
      if (drain_wait && (exp_words.size() == 0)) drain_wait = 1'b0;
      if (gap_left != 0) gap_left--;
      else if (!calm && !holding && ($urandom_range(0, 7) == 0)) gap_left = $urandom_range(1, 15);
      if ((gap_left == 0) && !drain_wait && (src_bytes.size() != 0)) begin
        in_word  <= src_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back the block up
  always @(negedge clk) begin : receiver
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    if (hold_left != 0) begin
      hold_left--;
    end else if (!hold_done && (accepted_n >= HOLD_AT)) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end else if (stall_left != 0) begin
      stall_left--;
    end else if (!calm && ($urandom_range(0, 5) == 0)) begin
      stall_left = $urandom_range(1, 15);
    end
    out_stall <= (hold_left != 0) || (stall_left != 0);
    holding   <= (hold_left != 0);
  end

  // Monitor: check each delivered result word, then predict from the accepted input word
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        checked_n++;
        if (exp_words.size() == 0) begin
          mismatch_n++;
          if (mismatch_n <= 10)
            $display("result %0d: no word expected, got cp=%h st=%0d chars=%0d bytes=%0d fin=%b",
                     checked_n, out_word.code_point, out_word.status, out_word.char_count,
                     out_word.bytes_consumed, out_word.final_result);
        end else begin
          want = exp_words.pop_front();
          if ((out_word.code_point !== want.code_point) ||
              (out_word.status !== want.status) ||
              (out_word.char_count !== want.char_count) ||
              (out_word.bytes_consumed !== want.bytes_consumed) ||
              (out_word.final_result !== want.final_result)) begin
            mismatch_n++;
            if (mismatch_n <= 10)
              $display("result %0d: expected cp=%h st=%0d chars=%0d bytes=%0d fin=%b,",
                       checked_n, want.code_point, want.status, want.char_count,
                       want.bytes_consumed, want.final_result,
                       " got cp=%h st=%0d chars=%0d bytes=%0d fin=%b",
                       out_word.code_point, out_word.status, out_word.char_count,
                       out_word.bytes_consumed, out_word.final_result);
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_byte(in_word);
        accepted_n <= accepted_n + 1;
      end
    end
    in_took <= rst_n && in_valid && !in_stall;
  end

  // Watchdog: give up on a hung run
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= LIMIT) begin
      $display("timeout after %0d cycles", cycle_n);
      $display("utf8_to_utf32_decoder_top test failed");
      $finish;
    end
  end

  initial begin
    clear_decoder();

    // Legal minimum of every sequence length, the maxima 7F and 10FFFF, and the restricted second bytes
    stream_buf = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F,
                   8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    flush_stream();
    // Stray continuation as a lead: rejected at once, rest dropped to the end mark
    stream_buf = '{8'h80, 8'hFF};
    flush_stream();
    // Overlong lead collects its continuation and is rejected on the end-marked byte
    stream_buf = '{8'hC0, 8'hAF};
    flush_stream();
    // Known-bad sequence cut short: exhaustion takes precedence
    stream_buf = '{8'hFC, 8'h80, 8'h80};
    flush_stream();
    // Overlong three-byte form: second byte below A0 after E0
    stream_buf = '{8'hE0, 8'h9F, 8'hBF};
    flush_stream();
    drain_point = src_bytes.size();

    while (src_bytes.size() < 680) add_random_stream();
    total_n = src_bytes.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every word to be taken, every result to arrive, then a short tail
    while (accepted_n != total_n) @(negedge clk);
    while (exp_words.size() != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);

    if ((mismatch_n == 0) && (exp_words.size() == 0)) begin
      $display("utf8_to_utf32_decoder_top test passed");
    end else begin
      if (exp_words.size() != 0) $display("%0d result words never arrived", exp_words.size());
      $display("utf8_to_utf32_decoder_top test failed");
    end
    $finish;
  end

endmodule

@@ utf8_to_utf32_decoder_top.f @@
rtl/utd_pkg.sv
rtl/utd_core.sv
rtl/utd_out_buf.sv
rtl/utd_top_unused_guard.sv
rtl/utf8_to_utf32_decoder_top.sv
sim/tb.sv
